// ----- src/binary_min_heap_priority_queue_defines.svh -----
// Assertion macros for the binary min-heap priority queue.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define BMH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define BMH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bmh_pkg.sv -----
// Shared types and constants for the binary min-heap priority queue.
// No dependencies.
package bmh_pkg;

  localparam int CAPACITY   = 1024;
  localparam int KEY_BITS   = 32;
  localparam int INDEX_BITS = 10;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  localparam int CHILD_BITS = CNT_BITS + 1;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_POP    = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    action_t                 action;
    logic [KEY_BITS-1:0]     key_weight;
    logic [INDEX_BITS-1:0]   first_vertex;
    logic [INDEX_BITS-1:0]   second_vertex;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic [KEY_BITS-1:0]     popped_weight;
    logic [INDEX_BITS-1:0]   popped_first;
    logic [INDEX_BITS-1:0]   popped_second;
    logic [KEY_BITS-1:0]     head_weight;
    logic [INDEX_BITS-1:0]   head_first;
    logic [INDEX_BITS-1:0]   head_second;
    logic [CNT_BITS-1:0]     occupancy;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [INDEX_BITS-1:0]   first;
    logic [INDEX_BITS-1:0]   second;
  } entry_t;

  typedef struct packed {
    logic                    we;
    logic [ADDR_BITS-1:0]    waddr;
    entry_t                  wdata;
    logic [ADDR_BITS-1:0]    raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_POP_RD,
    ST_POP_LD,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_DONE
  } state_t;

endpackage

// ----- src/bmh_store.sv -----
// Heap entry memory: one write port, one read port, registered read data.
// Depends on bmh_pkg.
module bmh_store (
  input  logic              clk,
  input  bmh_pkg::mem_req_t req,
  output bmh_pkg::entry_t   rdata
);
  import bmh_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/binary_min_heap_priority_queue.sv -----
// Binary min-heap priority queue top level: sequencer, root copy and result register.
// Depends on bmh_pkg, bmh_store and binary_min_heap_priority_queue_defines.svh.
//
// Holds up to 1024 entries (32-bit key, two 10-bit vertex indices) in one
// single-read-port memory with registered read data. One transaction is worked
// at a time. An insert reads the parent and writes one slot per level climbed;
// a pop reads the last entry, then both children and writes one slot per level
// descended. A new transaction is accepted while the previous result still
// waits on out_stall. The root is mirrored in a register, so head fields cost
// no extra read. No clearing pass after reset.
`include "binary_min_heap_priority_queue_defines.svh"
module binary_min_heap_priority_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bmh_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bmh_pkg::out_item_t  out_data
);
  import bmh_pkg::*;

  function automatic logic [ADDR_BITS-1:0] slot_addr(input logic [CHILD_BITS-1:0] slot);
    logic [CHILD_BITS-1:0] z;
    z = slot - CHILD_BITS'(1);
    return z[ADDR_BITS-1:0];
  endfunction

  state_t                state_r, state_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [CNT_BITS-1:0]   pos_r, pos_nxt;
  entry_t                item_r, item_nxt;
  entry_t                lc_r, lc_nxt;
  entry_t                head_r, head_nxt;
  entry_t                popped_r, popped_nxt;
  status_t               status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  mem_req_t              mem_req;
  entry_t                rdata;

  logic                  in_acc;
  logic                  out_free;
  logic [CHILD_BITS-1:0] pos_ext;
  logic [CHILD_BITS-1:0] lc;
  logic [CHILD_BITS-1:0] rc;
  logic [CHILD_BITS-1:0] count_ext;
  logic                  lc_ok;
  logic                  rc_ok;
  logic                  pick_l;
  logic                  pick_r;
  logic                  up_move;
  logic                  pos_is_root;
  logic                  full;
  logic                  empty;

  bmh_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  assign in_stall    = (state_r != ST_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign pos_ext     = {1'b0, pos_r};
  assign lc          = {pos_r, 1'b0};
  assign rc          = lc + CHILD_BITS'(1);
  assign count_ext   = {1'b0, count_r};
  assign lc_ok       = (lc <= count_ext);
  assign rc_ok       = (rc <= count_ext);
  assign pick_l      = (lc_r.key < item_r.key);
  assign pick_r      = rc_ok && (rdata.key < (pick_l ? lc_r.key : item_r.key));
  assign up_move     = (item_r.key < rdata.key);
  assign pos_is_root = (pos_r == CNT_BITS'(1));
  assign full        = (count_r == CNT_BITS'(CAPACITY));
  assign empty       = (count_r == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.action == ACT_INSERT) begin
            state_nxt = full ? ST_DONE : ST_UP_RD;
          end else begin
            state_nxt = empty ? ST_DONE : ST_POP_RD;
          end
        end
      end
      ST_UP_RD:  state_nxt = pos_is_root ? ST_DONE : ST_UP_CMP;
      ST_UP_CMP: state_nxt = up_move ? ST_UP_RD : ST_DONE;
      ST_POP_RD: state_nxt = ST_POP_LD;
      ST_POP_LD: state_nxt = empty ? ST_DONE : ST_DN_RDL;
      ST_DN_RDL: state_nxt = lc_ok ? ST_DN_RDR : ST_DONE;
      ST_DN_RDR: state_nxt = ST_DN_CMP;
      ST_DN_CMP: state_nxt = (pick_l || pick_r) ? ST_DN_RDL : ST_DONE;
      ST_DONE:   state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    item_nxt      = item_r;
    lc_nxt        = lc_r;
    head_nxt      = head_r;
    popped_nxt    = popped_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_req       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          status_nxt = STAT_DONE;
          popped_nxt = '0;
          if (in_data.action == ACT_INSERT) begin
            if (full) begin
              status_nxt = STAT_FULL;
            end else begin
              count_nxt       = count_r + CNT_BITS'(1);
              pos_nxt         = count_r + CNT_BITS'(1);
              item_nxt.key    = in_data.key_weight;
              item_nxt.first  = in_data.first_vertex;
              item_nxt.second = in_data.second_vertex;
            end
          end else begin
            if (empty) begin
              status_nxt = STAT_EMPTY;
            end else begin
              popped_nxt = head_r;
            end
          end
        end
      end
      ST_UP_RD: begin
        if (pos_is_root) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = slot_addr(pos_ext);
          mem_req.wdata = item_r;
        end else begin
          mem_req.raddr = slot_addr({2'b00, pos_r[CNT_BITS-1:1]});
        end
      end
      ST_UP_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = slot_addr(pos_ext);
        if (up_move) begin
          mem_req.wdata = rdata;
          pos_nxt       = {1'b0, pos_r[CNT_BITS-1:1]};
        end else begin
          mem_req.wdata = item_r;
        end
      end
      ST_POP_RD: begin
        mem_req.raddr = slot_addr(count_ext);
        count_nxt     = count_r - CNT_BITS'(1);
      end
      ST_POP_LD: begin
        item_nxt = rdata;
        pos_nxt  = CNT_BITS'(1);
      end
      ST_DN_RDL: begin
        if (lc_ok) begin
          mem_req.raddr = slot_addr(lc);
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = slot_addr(pos_ext);
          mem_req.wdata = item_r;
        end
      end
      ST_DN_RDR: begin
        lc_nxt        = rdata;
        mem_req.raddr = slot_addr(rc);
      end
      ST_DN_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = slot_addr(pos_ext);
        if (pick_r) begin
          mem_req.wdata = rdata;
          pos_nxt       = rc[CNT_BITS-1:0];
        end else if (pick_l) begin
          mem_req.wdata = lc_r;
          pos_nxt       = lc[CNT_BITS-1:0];
        end else begin
          mem_req.wdata = item_r;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.popped_weight = popped_r.key;
          out_data_nxt.popped_first  = popped_r.first;
          out_data_nxt.popped_second = popped_r.second;
          out_data_nxt.head_weight   = empty ? '0 : head_r.key;
          out_data_nxt.head_first    = empty ? '0 : head_r.first;
          out_data_nxt.head_second   = empty ? '0 : head_r.second;
          out_data_nxt.occupancy     = count_r;
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
    // mirror the root slot
    if (mem_req.we && (mem_req.waddr == '0)) begin
      head_nxt = mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    item_r     <= item_nxt;
    lc_r       <= lc_nxt;
    head_r     <= head_nxt;
    popped_r   <= popped_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BMH_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_BITS'(CAPACITY), "entry count above capacity")
  `BMH_ASSERT_NOW(a_write_in_heap, mem_req.we, ({1'b0, mem_req.waddr} < count_r), "write outside occupied slots")
  `BMH_ASSERT_NEXT(a_full_keeps_count, in_acc && (in_data.action == ACT_INSERT) && full, $stable(count_r), "rejected insert changed count")
  `BMH_ASSERT_NOW(a_result_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE, "result raised outside done state")

endmodule
